### src/sctt_pkg.sv
package sctt_pkg;

  // Coherence states
  localparam logic [2:0] ST_I = 3'd0;
  localparam logic [2:0] ST_S = 3'd1;
  localparam logic [2:0] ST_E = 3'd2;
  localparam logic [2:0] ST_O = 3'd3;
  localparam logic [2:0] ST_M = 3'd4;

  // Commands, shared by the request input and the bus command output
  localparam logic [3:0] CMD_READ        = 4'd0;
  localparam logic [3:0] CMD_WRITE       = 4'd1;
  localparam logic [3:0] CMD_SWAP        = 4'd2;
  localparam logic [3:0] CMD_SOFTPF      = 4'd3;
  localparam logic [3:0] CMD_HARDPF      = 4'd4;
  localparam logic [3:0] CMD_READEX      = 4'd5;
  localparam logic [3:0] CMD_UPGRADE     = 4'd6;
  localparam logic [3:0] CMD_INV         = 4'd7;
  localparam logic [3:0] CMD_WINV        = 4'd8;
  localparam logic [3:0] CMD_READRESP    = 4'd9;
  localparam logic [3:0] CMD_READEXRESP  = 4'd10;

  // Operation kinds
  localparam logic [1:0] OP_REQ   = 2'd0;
  localparam logic [1:0] OP_RESP  = 2'd1;
  localparam logic [1:0] OP_SNOOP = 2'd2;

  // Protocol variants; bit 0 enables Exclusive, bit 1 enables Owned
  localparam logic [1:0] PV_MSI   = 2'd0;
  localparam logic [1:0] PV_MESI  = 2'd1;
  localparam logic [1:0] PV_MOSI  = 2'd2;
  localparam logic [1:0] PV_MOESI = 2'd3;

  // Configuration register indexes
  localparam logic CFG_PROTOCOL_VARIANT = 1'b0;
  localparam logic CFG_USE_UPGRADES     = 1'b1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [1:0] protocol_variant;
    logic       use_upgrades;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] command;
    logic [2:0] line_state;
    logic       block_present;
    logic       shared_line_in;
  } item_t;

  typedef struct packed {
    logic [3:0] bus_command;
    logic [2:0] next_state;
    logic       supply_data;
    logic       assert_shared;
    logic       illegal_transition;
    logic       bad_config;
  } result_t;

endpackage

### src/sctt_decode.sv
module sctt_decode (
  input  sctt_pkg::cfg_t    cfg,
  input  sctt_pkg::item_t   item,
  output sctt_pkg::result_t res
);
  import sctt_pkg::*;

  logic       has_e;
  logic       has_o;
  logic       upg;
  logic [3:0] ws_cmd;
  logic [3:0] ws_resp;
  logic       ok;
  logic [3:0] bus;
  logic [2:0] nxt;
  logic       sup;
  logic       shr;
  logic       owner_ok;

  assign has_e    = cfg.protocol_variant[0];
  assign has_o    = cfg.protocol_variant[1];
  assign upg      = cfg.use_upgrades;
  assign ws_cmd   = upg ? CMD_UPGRADE : CMD_READEX;
  assign ws_resp  = upg ? CMD_UPGRADE : CMD_READEXRESP;
  // S, or O where the variant has Owned: both take the write-to-shared path
  assign owner_ok = (item.line_state == ST_S) || ((item.line_state == ST_O) && has_o);

  always_comb begin
    ok  = 1'b0;
    bus = CMD_READ;
    nxt = item.line_state;
    sup = 1'b0;
    shr = 1'b0;
    case (item.operation)
      OP_REQ: begin
        if (item.line_state == ST_I) begin
          if (item.command inside {CMD_READ, CMD_SOFTPF, CMD_HARDPF}) begin
            bus = CMD_READ;
            ok  = 1'b1;
          end else if (item.command inside {CMD_WRITE, CMD_SWAP}) begin
            bus = CMD_READEX;
            ok  = 1'b1;
          end
        end else if (owner_ok && (item.command inside {CMD_WRITE, CMD_SWAP})) begin
          bus = ws_cmd;
          ok  = 1'b1;
        end
      end
      OP_RESP: begin
        if ((item.line_state == ST_I) && (item.command == CMD_READEXRESP)) begin
          nxt = ST_M;
          ok  = 1'b1;
        end else if ((item.line_state == ST_I) && (item.command == CMD_READRESP)) begin
          nxt = (has_e && !item.shared_line_in) ? ST_E : ST_S;
          ok  = 1'b1;
        end else if (owner_ok && (item.command == ws_resp)) begin
          nxt = ST_M;
          ok  = 1'b1;
        end
      end
      OP_SNOOP: begin
        if (!item.block_present) begin
          ok = 1'b1;
        end else begin
          case (item.line_state)
            ST_I: begin
              if ((item.command inside {CMD_READ, CMD_READEX}) ||
                  ((item.command == CMD_UPGRADE) && upg)) begin
                ok = 1'b1;
              end else if (item.command inside {CMD_INV, CMD_WINV}) begin
                nxt = ST_I;
                ok  = 1'b1;
              end
            end
            ST_S: begin
              if (item.command == CMD_READ) begin
                shr = has_e;
                ok  = 1'b1;
              end else if ((item.command inside {CMD_READEX, CMD_INV, CMD_WINV}) ||
                           ((item.command == CMD_UPGRADE) && upg)) begin
                nxt = ST_I;
                ok  = 1'b1;
              end
            end
            ST_M: begin
              if (item.command == CMD_READ) begin
                nxt = has_o ? ST_O : ST_S;
                sup = 1'b1;
                shr = 1'b1;
                ok  = 1'b1;
              end else if (item.command == CMD_READEX) begin
                nxt = ST_I;
                sup = 1'b1;
                ok  = 1'b1;
              end else if (item.command inside {CMD_INV, CMD_WINV}) begin
                nxt = ST_I;
                ok  = 1'b1;
              end
            end
            ST_E: begin
              if (has_e) begin
                if (item.command == CMD_READ) begin
                  nxt = ST_S;
                  shr = 1'b1;
                  ok  = 1'b1;
                end else if (item.command inside {CMD_READEX, CMD_INV, CMD_WINV}) begin
                  nxt = ST_I;
                  ok  = 1'b1;
                end
              end
            end
            ST_O: begin
              if (has_o) begin
                if (item.command == CMD_READ) begin
                  nxt = ST_O;
                  sup = 1'b1;
                  shr = 1'b1;
                  ok  = 1'b1;
                end else if (item.command == CMD_READEX) begin
                  nxt = ST_I;
                  sup = 1'b1;
                  ok  = 1'b1;
                end else if (item.command inside {CMD_UPGRADE, CMD_INV, CMD_WINV}) begin
                  nxt = ST_I;
                  ok  = 1'b1;
                end
              end
            end
            default: ok = 1'b0;
          endcase
        end
      end
      default: ok = 1'b0;
    endcase

    // Undefined pair: drop every action, keep the state
    if (!ok) begin
      bus = CMD_READ;
      nxt = item.line_state;
      sup = 1'b0;
      shr = 1'b0;
    end
  end

  assign res.bus_command        = bus;
  assign res.next_state         = nxt;
  assign res.supply_data        = sup;
  assign res.assert_shared      = shr;
  assign res.illegal_transition = !ok;
  assign res.bad_config         = has_o && !upg;

endmodule

### src/snoop_coherence_transition_table.sv
// Snooping coherence transition table for MSI, MESI, MOSI and MOESI, with or
// without upgrade transactions. Each input beat carries one processor request,
// bus response or bus snoop; each gives exactly one output beat holding the
// bus command to issue (requests), the new line state (responses and snoops),
// the supply and shared-line flags (snoops), an illegal-pair flag and a
// bad-configuration flag (Owned variant without upgrades). The block takes one
// beat per cycle unless m_tready stalls it; a beat passes the input register,
// then the table decode into the output register. The two registers form a
// two-deep pipeline, so a beat is still taken while a result waits on m_tready
// if the input register is empty. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle, which the block does not
// enforce; index 0 is protocol_variant (0 msi, 1 mesi, 2 mosi, 3 moesi), index
// 1 is use_upgrades. After reset the block runs MSI with upgrades on.
module snoop_coherence_transition_table (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [1:0]                        cfg_data,
  // Input beats
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: command[3:0], line_state[6:4], block_present[7],
  //          shared_line_in[8], zero fill [15:9]
  input  logic [sctt_pkg::IN_DATA_W-1:0]    s_tdata,
  // s_tuser: operation[1:0]
  input  logic [1:0]                        s_tuser,
  // Output beats
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: bus_command[3:0], next_state[6:4], supply_data[7],
  //          assert_shared[8], illegal_transition[9], bad_config[10],
  //          zero fill [15:11]
  output logic [sctt_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import sctt_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t dec_res;
  logic    out_load;
  logic    in_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_variant <= PV_MSI;
      cfg.use_upgrades     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROTOCOL_VARIANT: cfg.protocol_variant <= cfg_data;
        CFG_USE_UPGRADES:     cfg.use_upgrades     <= cfg_data[0];
        default:              cfg.use_upgrades     <= cfg.use_upgrades;
      endcase
    end
  end

  // Advance the output register when it is empty or being drained;
  // advance the input register when it is empty or moving forward.
  assign out_load = !out_valid || m_tready;
  assign in_load  = !in_valid || out_load;
  assign s_tready = in_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && s_tvalid) begin
      in_item.operation      <= s_tuser;
      in_item.command        <= s_tdata[3:0];
      in_item.line_state     <= s_tdata[6:4];
      in_item.block_present  <= s_tdata[7];
      in_item.shared_line_in <= s_tdata[8];
    end
  end

  sctt_decode u_decode (
    .cfg  (cfg),
    .item (in_item),
    .res  (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  // Hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_res <= dec_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W - 11){1'b0}},
                     out_res.bad_config,
                     out_res.illegal_transition,
                     out_res.assert_shared,
                     out_res.supply_data,
                     out_res.next_state,
                     out_res.bus_command};

endmodule

### sim/snoop_coherence_transition_table_tb.sv
module snoop_coherence_transition_table_tb;
  import sctt_pkg::*;

  // Abort a run that hangs.
  localparam int CYCLE_LIMIT = 400000;
  // Beats per random segment; 16 segments make about 1850 beats in total
  localparam int SEG_BEATS   = 116;

  typedef struct packed {
    cfg_t    setting;
    item_t   txn;
    logic    known;     // expected result typed in by hand
    result_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [1:0]            cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // command, line_state, block_present, shared_line_in
  logic [1:0]            s_tuser;   // operation
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;   // bus_command, next_state, supply_data,
                                    // assert_shared, illegal_transition, bad_config

  // Expected results in beat order, the configuration the predictor decodes
  // against, and the directed rows
  result_t  pending_results[$];
  cfg_t     active_cfg;
  dir_row_t directed_rows[$];

  int cycles = 0;
  int mismatches = 0;
  int send_idle_pct;
  int recv_stall_pct;

  snoop_coherence_transition_table uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decode one transaction against a configuration; beside the error flags, bus command
  // for requests, new state for responses, new state plus supply/shared for snoops.
  function automatic result_t predict_coherence(input cfg_t c, input item_t t);
    result_t    r;
    logic       has_e;
    logic       has_o;
    logic       upg;
    logic       ok;
    logic       owned_ok;
    logic [3:0] wr_shared_cmd;
    logic [3:0] wr_shared_resp;
    has_e          = c.protocol_variant[0];
    has_o          = c.protocol_variant[1];
    upg            = c.use_upgrades;
    owned_ok       = (t.line_state == ST_O) && has_o;
    wr_shared_cmd  = upg ? CMD_UPGRADE : CMD_READEX;
    wr_shared_resp = upg ? CMD_UPGRADE : CMD_READEXRESP;
    r              = '0;
    r.next_state   = t.line_state;
    ok             = 1'b0;
    case (t.operation)
      OP_REQ: begin
        if (t.line_state == ST_I) begin
          if (t.command == CMD_READ || t.command == CMD_SOFTPF ||
              t.command == CMD_HARDPF) begin
            r.bus_command = CMD_READ;
            ok = 1'b1;
          end else if (t.command == CMD_WRITE || t.command == CMD_SWAP) begin
            r.bus_command = CMD_READEX;
            ok = 1'b1;
          end
        end else if (t.line_state == ST_S || owned_ok) begin
          if (t.command == CMD_WRITE || t.command == CMD_SWAP) begin
            r.bus_command = wr_shared_cmd;
            ok = 1'b1;
          end
        end
      end
      OP_RESP: begin
        if (t.line_state == ST_I && t.command == CMD_READEXRESP) begin
          r.next_state = ST_M;
          ok = 1'b1;
        end else if (t.line_state == ST_I && t.command == CMD_READRESP) begin
          r.next_state = (has_e && !t.shared_line_in) ? ST_E : ST_S;
          ok = 1'b1;
        end else if ((t.line_state == ST_S || owned_ok) &&
                     t.command == wr_shared_resp) begin
          r.next_state = ST_M;
          ok = 1'b1;
        end
      end
      OP_SNOOP: begin
        if (!t.block_present) begin
          ok = 1'b1;
        end else if (t.line_state == ST_I) begin
          if (t.command == CMD_READ || t.command == CMD_READEX ||
              (t.command == CMD_UPGRADE && upg)) begin
            ok = 1'b1;
          end else if (t.command == CMD_INV || t.command == CMD_WINV) begin
            r.next_state = ST_I;
            ok = 1'b1;
          end
        end else if (t.line_state == ST_S) begin
          if (t.command == CMD_READ) begin
            r.assert_shared = has_e;
            ok = 1'b1;
          end else if (t.command == CMD_READEX || t.command == CMD_INV ||
                       t.command == CMD_WINV || (t.command == CMD_UPGRADE && upg)) begin
            r.next_state = ST_I;
            ok = 1'b1;
          end
        end else if (t.line_state == ST_M) begin
          if (t.command == CMD_READ) begin
            r.next_state    = has_o ? ST_O : ST_S;
            r.supply_data   = 1'b1;
            r.assert_shared = 1'b1;
            ok = 1'b1;
          end else if (t.command == CMD_READEX) begin
            r.next_state  = ST_I;
            r.supply_data = 1'b1;
            ok = 1'b1;
          end else if (t.command == CMD_INV || t.command == CMD_WINV) begin
            r.next_state = ST_I;
            ok = 1'b1;
          end
        end else if (t.line_state == ST_E && has_e) begin
          if (t.command == CMD_READ) begin
            r.next_state    = ST_S;
            r.assert_shared = 1'b1;
            ok = 1'b1;
          end else if (t.command == CMD_READEX || t.command == CMD_INV ||
                       t.command == CMD_WINV) begin
            r.next_state = ST_I;
            ok = 1'b1;
          end
        end else if (owned_ok) begin
          if (t.command == CMD_READ) begin
            r.next_state    = ST_O;
            r.supply_data   = 1'b1;
            r.assert_shared = 1'b1;
            ok = 1'b1;
          end else if (t.command == CMD_READEX) begin
            r.next_state  = ST_I;
            r.supply_data = 1'b1;
            ok = 1'b1;
          end else if (t.command == CMD_UPGRADE || t.command == CMD_INV ||
                       t.command == CMD_WINV) begin
            r.next_state = ST_I;
            ok = 1'b1;
          end
        end
      end
      default: ok = 1'b0;  // operation three is never defined
    endcase
    // An undefined pair keeps the state and drops every action
    if (!ok) begin
      r            = '0;
      r.next_state = t.line_state;
    end
    r.illegal_transition = !ok;
    r.bad_config         = has_o && !upg;
    return r;
  endfunction

  // Mostly well-formed traffic: commands that fit the operation, states in
  // range. A slice of noise covers the undefined encodings of every field.
  function automatic item_t draw_transaction();
    item_t t;
    int    pick;
    pick             = $urandom_range(99);
    t.block_present  = ($urandom_range(99) < 85);
    t.shared_line_in = 1'($urandom_range(1));
    if (pick < 10) begin
      t.operation     = 2'($urandom_range(3));
      t.command       = 4'($urandom_range(15));
      t.line_state    = 3'($urandom_range(7));
      t.block_present = 1'($urandom_range(1));
    end else begin
      t.operation  = 2'($urandom_range(2));   // request, response or snoop
      t.line_state = 3'($urandom_range(4));   // I through M
      if (pick < 30) begin
        t.command = 4'($urandom_range(10));
      end else begin
        case (t.operation)
          OP_REQ: t.command = 4'($urandom_range(4));  // Read up to HardPF
          OP_RESP: begin
            case ($urandom_range(2))
              0:       t.command = CMD_READRESP;
              1:       t.command = CMD_READEXRESP;
              default: t.command = CMD_UPGRADE;
            endcase
          end
          default: begin
            case ($urandom_range(4))
              0:       t.command = CMD_READ;
              1:       t.command = CMD_READEX;
              2:       t.command = CMD_UPGRADE;
              3:       t.command = CMD_INV;
              default: t.command = CMD_WINV;
            endcase
          end
        endcase
      end
    end
    return t;
  endfunction

  function automatic void add_row(input cfg_t c, input item_t t, input logic known,
                                  input result_t want);
    dir_row_t row;
    row.setting = c;
    row.txn     = t;
    row.known   = known;
    row.want    = want;
    directed_rows.push_back(row);
  endfunction

  // Offer one beat, holding it until the block takes it. Valid stays high
  // into the next beat unless the random gap drops it.
  task automatic send_beat(input item_t t, input logic known, input result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= t.operation;
    s_tdata  <= {7'd0, t.shared_line_in, t.block_present, t.line_state, t.command};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(known ? want : predict_coherence(active_cfg, t));
    @(negedge clk);
  endtask

  // Drop valid and wait until every result is back and the pipe is empty
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Switch configuration only with the block idle; the upper data bit of the
  // upgrade register is noise the block must ignore.
  task automatic load_config(input cfg_t c, input logic force_write);
    if (force_write || c != active_cfg) begin
      drain_results();
      write_reg(CFG_PROTOCOL_VARIANT, c.protocol_variant);
      write_reg(CFG_USE_UPGRADES, {1'($urandom_range(1)), c.use_upgrades});
      active_cfg = c;
    end
  endtask

  // Receiver: stall at the phase's rate, change only at the falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Check each output beat against the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    string   got_s;
    string   want_s;
    if (!rst && m_tvalid && m_tready) begin
      got.bus_command        = m_tdata[3:0];
      got.next_state         = m_tdata[6:4];
      got.supply_data        = m_tdata[7];
      got.assert_shared      = m_tdata[8];
      got.illegal_transition = m_tdata[9];
      got.bad_config         = m_tdata[10];
      got_s = $sformatf("bus=%0d nxt=%0d sup=%b shr=%b ill=%b bad=%b",
                        got.bus_command, got.next_state, got.supply_data,
                        got.assert_shared, got.illegal_transition, got.bad_config);
      if (pending_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 40)
          $display("%0t: unexpected beat, actual %s", $time, got_s);
      end else begin
        want = pending_results.pop_front();
        if (got.bus_command !== want.bus_command || got.next_state !== want.next_state ||
            got.supply_data !== want.supply_data ||
            got.assert_shared !== want.assert_shared ||
            got.illegal_transition !== want.illegal_transition ||
            got.bad_config !== want.bad_config) begin
          mismatches = mismatches + 1;
          want_s = $sformatf("bus=%0d nxt=%0d sup=%b shr=%b ill=%b bad=%b",
                             want.bus_command, want.next_state, want.supply_data,
                             want.assert_shared, want.illegal_transition,
                             want.bad_config);
          if (mismatches <= 40)
            $display("%0t: mismatch expected %s, actual %s", $time, want_s, got_s);
        end
      end
    end
  end

  initial begin
    cfg_t    seg_cfg;
    item_t   t;
    dir_row_t row;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_PROTOCOL_VARIANT;
    cfg_data       = 2'd0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = OP_REQ;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Power-up setting: MSI with upgrades
    active_cfg     = '{PV_MSI, 1'b1};

    // Directed rows: reset setting first, then every variant, ending on the
    // Owned-without-upgrades setting and plain MSI without upgrades
    add_row('{PV_MSI, 1'b1}, '{OP_REQ, CMD_READ, ST_I, 1'b0, 1'b0}, 1'b1,
            '{CMD_READ, ST_I, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row('{PV_MSI, 1'b1}, '{OP_REQ, CMD_WRITE, ST_S, 1'b1, 1'b1}, 1'b1,
            '{CMD_UPGRADE, ST_S, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row('{PV_MSI, 1'b1}, '{OP_REQ, CMD_SWAP, ST_I, 1'b0, 1'b0}, 1'b1,
            '{CMD_READEX, ST_I, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row('{PV_MSI, 1'b1}, '{OP_REQ, CMD_HARDPF, ST_I, 1'b1, 1'b0}, 1'b0, '0);
    // Top of the command and state fields: undefined command and state
    add_row('{PV_MSI, 1'b1}, '{OP_REQ, 4'd15, 3'd7, 1'b1, 1'b1}, 1'b1,
            '{4'd0, 3'd7, 1'b0, 1'b0, 1'b1, 1'b0});
    add_row('{PV_MSI, 1'b1}, '{OP_RESP, CMD_READEXRESP, ST_I, 1'b0, 1'b0}, 1'b0, '0);
    add_row('{PV_MSI, 1'b1}, '{OP_RESP, CMD_READRESP, ST_I, 1'b0, 1'b1}, 1'b0, '0);
    add_row('{PV_MSI, 1'b1}, '{OP_SNOOP, CMD_READ, ST_M, 1'b1, 1'b0}, 1'b0, '0);
    // Snoop that misses: state kept, no action, not flagged
    add_row('{PV_MSI, 1'b1}, '{OP_SNOOP, CMD_READ, ST_E, 1'b0, 1'b0}, 1'b1,
            '{4'd0, ST_E, 1'b0, 1'b0, 1'b0, 1'b0});
    // Exclusive in a variant without it
    add_row('{PV_MSI, 1'b1}, '{OP_SNOOP, CMD_READ, ST_E, 1'b1, 1'b0}, 1'b1,
            '{4'd0, ST_E, 1'b0, 1'b0, 1'b1, 1'b0});
    // Operation three is always undefined
    add_row('{PV_MSI, 1'b1}, '{2'd3, CMD_READ, ST_I, 1'b1, 1'b0}, 1'b1,
            '{4'd0, ST_I, 1'b0, 1'b0, 1'b1, 1'b0});
    add_row('{PV_MESI, 1'b1}, '{OP_RESP, CMD_READRESP, ST_I, 1'b0, 1'b0}, 1'b0, '0);
    add_row('{PV_MESI, 1'b1}, '{OP_RESP, CMD_READRESP, ST_I, 1'b0, 1'b1}, 1'b0, '0);
    add_row('{PV_MESI, 1'b1}, '{OP_SNOOP, CMD_READ, ST_S, 1'b1, 1'b0}, 1'b0, '0);
    add_row('{PV_MESI, 1'b1}, '{OP_SNOOP, CMD_READ, ST_E, 1'b1, 1'b0}, 1'b0, '0);
    add_row('{PV_MOSI, 1'b1}, '{OP_REQ, CMD_WRITE, ST_O, 1'b0, 1'b0}, 1'b0, '0);
    add_row('{PV_MOSI, 1'b1}, '{OP_SNOOP, CMD_READ, ST_M, 1'b1, 1'b0}, 1'b0, '0);
    add_row('{PV_MOSI, 1'b1}, '{OP_SNOOP, CMD_UPGRADE, ST_O, 1'b1, 1'b0}, 1'b0, '0);
    // Owned without upgrades: flagged, and a write to O falls back to ReadEx
    add_row('{PV_MOESI, 1'b0}, '{OP_REQ, CMD_WRITE, ST_O, 1'b0, 1'b0}, 1'b1,
            '{CMD_READEX, ST_O, 1'b0, 1'b0, 1'b0, 1'b1});
    add_row('{PV_MOESI, 1'b0}, '{OP_RESP, CMD_UPGRADE, ST_S, 1'b0, 1'b0}, 1'b0, '0);
    add_row('{PV_MOESI, 1'b0}, '{OP_RESP, CMD_READEXRESP, ST_S, 1'b0, 1'b0}, 1'b0, '0);
    add_row('{PV_MOESI, 1'b0}, '{OP_SNOOP, CMD_UPGRADE, ST_I, 1'b1, 1'b0}, 1'b0, '0);
    add_row('{PV_MOESI, 1'b0}, '{OP_SNOOP, CMD_READEX, ST_O, 1'b1, 1'b0}, 1'b0, '0);
    add_row('{PV_MSI, 1'b0}, '{OP_REQ, CMD_WRITE, ST_S, 1'b0, 1'b0}, 1'b0, '0);
    add_row('{PV_MSI, 1'b0}, '{OP_SNOOP, CMD_WINV, ST_M, 1'b1, 1'b0}, 1'b0, '0);

    // Hold reset, then release it at a falling edge
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, no idling on either side
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      load_config(row.setting, 1'b0);
      send_beat(row.txn, row.known, row.want);
    end

    // Random part: four idling phases, each across four settings; over the
    // sixteen segments every variant meets both upgrade settings twice
    for (int seg = 0; seg < 16; seg++) begin
      case (seg / 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      seg_cfg.protocol_variant = seg[1:0];
      seg_cfg.use_upgrades     = seg[2] ^ seg[0];
      load_config(seg_cfg, 1'b1);
      for (int n = 0; n < SEG_BEATS; n++) begin
        t = draw_transaction();
        send_beat(t, 1'b0, '0);
      end
    end

    // Let the last results out, then judge
    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/sctt_pkg.sv
src/sctt_decode.sv
src/snoop_coherence_transition_table.sv
sim/snoop_coherence_transition_table_tb.sv
